FILE: rtl/oads_pkg.sv
// ============================================================================
// oads_pkg
// Shared types and constants of the obstacle avoiding drive sequencer.
// ============================================================================
package oads_pkg;

  localparam int unsigned NowW   = 32;
  localparam int unsigned EchoW  = 15;
  localparam int unsigned ChoiceW = 4;
  localparam int unsigned PwmW   = 8;
  localparam int unsigned LenW   = 11;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_TURN = 2'd1,
    MODE_BACK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_STOP   = 3'd0,
    CMD_FWD    = 3'd1,
    CMD_BACK   = 3'd2,
    CMD_SPIN_L = 3'd3,
    CMD_SPIN_R = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_DRIVE_SPEED = 2'd0,
    REG_NEAR_LIMIT  = 2'd1,
    REG_WARN_LIMIT  = 2'd2
  } reg_idx_t;

  localparam logic [PwmW-1:0]  DriveSpeedReset = 8'd135;
  localparam logic [EchoW-1:0] NearLimitReset  = 15'd750;
  localparam logic [EchoW-1:0] WarnLimitReset  = 15'd1200;

  localparam logic [LenW-1:0] LenReverse   = 11'd1000;
  localparam logic [LenW-1:0] LenShortTurn = 11'd800;
  localparam logic [LenW-1:0] LenLongTurn  = 11'd1500;
  localparam logic [LenW-1:0] LenStraight  = 11'd2000;

  localparam logic [ChoiceW-1:0] ChoiceSpinL = 4'd1;
  localparam logic [ChoiceW-1:0] ChoiceSpinR = 4'd2;

endpackage

FILE: rtl/oads_if.sv
// ============================================================================
// oads_if
// Handshake channels for control steps in and motor drive words out.
// ============================================================================
interface oads_step_if;
  logic                         valid;
  logic                         ready;
  logic [oads_pkg::NowW-1:0]    now_ms;
  logic [oads_pkg::EchoW-1:0]   echo_us;
  logic                         rand_long_turn;
  logic                         rand_turn_right;
  logic [oads_pkg::ChoiceW-1:0] rand_choice;

  modport source (output valid, now_ms, echo_us, rand_long_turn, rand_turn_right,
                  rand_choice, input ready);
  modport sink (input valid, now_ms, echo_us, rand_long_turn, rand_turn_right,
                rand_choice, output ready);
endinterface

interface oads_drive_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                right_dir;
  logic [oads_pkg::PwmW-1:0] right_pwm;
  logic [1:0]                left_dir;
  logic [oads_pkg::PwmW-1:0] left_pwm;
  logic [1:0]                mode;

  modport source (output valid, right_dir, right_pwm, left_dir, left_pwm, mode,
                  input ready);
  modport sink (input valid, right_dir, right_pwm, left_dir, left_pwm, mode,
                output ready);
endinterface

FILE: rtl/obstacle_avoid_drive_sequencer_core.sv
// ============================================================================
// obstacle_avoid_drive_sequencer_core
// Wander controller: mode machine over reverse, turn and forward phases that
// reports the drive for both tracks once per control step.
// ============================================================================
// A word accepted on the step channel loads the input register and is presented on
// the output when it moves on into the result register.
// Throughput: one word per cycle unless the drive channel stalls; the mode state
// changes as the result register loads, so the following word sees it at once.
// Reset: mode forward, phase start and length zero, drive stopped, registers
// at their defaults; the block accepts words as soon as reset is released.
module obstacle_avoid_drive_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  oads_step_if.sink                       step,
  oads_drive_if.source                    drive,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [oads_pkg::CfgAddrW-1:0]   paddr,
  input  logic [oads_pkg::CfgDataW-1:0]   pwdata,
  output logic [oads_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);
  import oads_pkg::*;

  logic [PwmW-1:0]  drive_speed;
  logic [EchoW-1:0] near_limit_us;
  logic [EchoW-1:0] warn_limit_us;
  reg_idx_t         reg_idx;

  mode_t           mode_reg;
  logic [NowW-1:0] phase_start;
  logic [LenW-1:0] phase_length;
  cmd_t            drive_cmd;

  logic               s1_valid;
  logic [NowW-1:0]    s1_now;
  logic [EchoW-1:0]   s1_echo;
  logic               s1_long_turn;
  logic               s1_turn_right;
  logic [ChoiceW-1:0] s1_choice;
  logic               s1_adv;

  logic            expired;
  logic            is_near;
  logic            is_warn;
  cmd_t            spin;
  logic            start_phase;
  mode_t           mode_next;
  logic [LenW-1:0] length_next;
  cmd_t            cmd_next;
  dir_t            right_dir_next;
  dir_t            left_dir_next;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DRIVE_SPEED: prdata = {{(CfgDataW-PwmW){1'b0}}, drive_speed};
      REG_NEAR_LIMIT:  prdata = {{(CfgDataW-EchoW){1'b0}}, near_limit_us};
      REG_WARN_LIMIT:  prdata = {{(CfgDataW-EchoW){1'b0}}, warn_limit_us};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed   <= DriveSpeedReset;
      near_limit_us <= NearLimitReset;
      warn_limit_us <= WarnLimitReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DRIVE_SPEED: drive_speed   <= pwdata[PwmW-1:0];
        REG_NEAR_LIMIT:  near_limit_us <= pwdata[EchoW-1:0];
        REG_WARN_LIMIT:  warn_limit_us <= pwdata[EchoW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid && (!drive.valid || drive.ready);
  assign step.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step.ready) begin
      s1_valid <= step.valid;
    end
    if (step.valid && step.ready) begin
      s1_now        <= step.now_ms;
      s1_echo       <= step.echo_us;
      s1_long_turn  <= step.rand_long_turn;
      s1_turn_right <= step.rand_turn_right;
      s1_choice     <= step.rand_choice;
    end
  end

  assign expired = (s1_now - phase_start) >= {{(NowW-LenW){1'b0}}, phase_length};
  assign is_near = (s1_echo != '0) && (s1_echo < near_limit_us);
  assign is_warn = (s1_echo != '0) && (s1_echo < warn_limit_us);
  assign spin    = s1_turn_right ? CMD_SPIN_R : CMD_SPIN_L;

  always_comb begin
    start_phase = 1'b0;
    mode_next   = MODE_FWD;
    length_next = LenStraight;
    cmd_next    = CMD_FWD;
    if (is_near) begin
      if (mode_reg != MODE_BACK) begin
        start_phase = 1'b1;
        mode_next   = MODE_BACK;
        length_next = LenReverse;
        cmd_next    = CMD_BACK;
      end else if (expired) begin
        start_phase = 1'b1;
        mode_next   = MODE_TURN;
        length_next = LenShortTurn;
        cmd_next    = spin;
      end
    end else if (is_warn) begin
      if (expired && mode_reg != MODE_TURN) begin
        start_phase = 1'b1;
        mode_next   = MODE_TURN;
        length_next = s1_long_turn ? LenLongTurn : LenShortTurn;
        cmd_next    = spin;
      end else if (expired) begin
        start_phase = 1'b1;
      end
    end else if (mode_reg != MODE_FWD || expired) begin
      start_phase = 1'b1;
      if (s1_choice == ChoiceSpinL) begin
        length_next = LenLongTurn;
        cmd_next    = CMD_SPIN_L;
      end else if (s1_choice == ChoiceSpinR) begin
        length_next = LenLongTurn;
        cmd_next    = CMD_SPIN_R;
      end
    end
    if (!start_phase) begin
      mode_next = mode_reg;
      cmd_next  = drive_cmd;
    end
  end

  always_comb begin
    unique case (cmd_next)
      CMD_FWD: begin
        right_dir_next = DIR_FWD;
        left_dir_next  = DIR_FWD;
      end
      CMD_BACK: begin
        right_dir_next = DIR_BACK;
        left_dir_next  = DIR_BACK;
      end
      CMD_SPIN_L: begin
        right_dir_next = DIR_FWD;
        left_dir_next  = DIR_BACK;
      end
      CMD_SPIN_R: begin
        right_dir_next = DIR_BACK;
        left_dir_next  = DIR_FWD;
      end
      default: begin
        right_dir_next = DIR_STOP;
        left_dir_next  = DIR_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_FWD;
      phase_start  <= '0;
      phase_length <= '0;
      drive_cmd    <= CMD_STOP;
      drive.valid  <= 1'b0;
    end else begin
      if (s1_adv && start_phase) begin
        mode_reg     <= mode_next;
        phase_start  <= s1_now;
        phase_length <= length_next;
        drive_cmd    <= cmd_next;
      end
      if (s1_adv) begin
        drive.valid <= 1'b1;
      end else if (drive.ready) begin
        drive.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive.right_dir <= right_dir_next;
      drive.right_pwm <= (right_dir_next != DIR_STOP) ? drive_speed : '0;
      drive.left_dir  <= left_dir_next;
      drive.left_pwm  <= (left_dir_next != DIR_STOP) ? drive_speed : '0;
      drive.mode      <= mode_next;
    end
  end

  a_back_drives_back: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_BACK |-> drive_cmd == CMD_BACK)
    else $error("reverse mode without reverse drive");

  a_step_leaves_drive: assert property (@(posedge clk) disable iff (rst)
    $past(s1_adv) |-> (drive_cmd != CMD_STOP && phase_length != '0))
    else $error("processed step left drive stopped or phase length zero");

  a_tracks_same_pwm: assert property (@(posedge clk) disable iff (rst)
    drive.valid |-> drive.left_pwm == drive.right_pwm)
    else $error("track PWM values differ");

endmodule

FILE: tb/sv/oads_drive_checker.sv
// ----------------------------------------------------------------------------
// oads_drive_checker
// Watches the step and drive channels and the register port of the drive
// sequencer. It keeps its own copy of the mode machine and the registers,
// predicts the drive word of every accepted step, and compares each accepted
// drive word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module oads_drive_checker (
  input  logic                          clk,
  input  logic                          rst,
  oads_step_if                          step,
  oads_drive_if                         drive,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oads_pkg::CfgAddrW-1:0] paddr,
  input  logic [oads_pkg::CfgDataW-1:0] pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import oads_pkg::*;

  typedef struct packed {
    dir_t            right_dir;
    logic [PwmW-1:0] right_pwm;
    dir_t            left_dir;
    logic [PwmW-1:0] left_pwm;
    mode_t           mode;
  } drive_word_t;

  mode_t            mode_q;
  logic [NowW-1:0]  start_q;
  logic [LenW-1:0]  len_q;
  cmd_t             cmd_q;
  logic [PwmW-1:0]  speed_q;
  logic [EchoW-1:0] near_q;
  logic [EchoW-1:0] warn_q;
  drive_word_t      expected_drive_q[$];

  task automatic enter_phase(input mode_t m, input logic [NowW-1:0] now,
                             input logic [LenW-1:0] len, input cmd_t cmd);
    mode_q  = m;
    start_q = now;
    len_q   = len;
    cmd_q   = cmd;
  endtask

  task automatic predict_drive(output drive_word_t d);
    logic            expired;
    cmd_t            spin;
    dir_t            rd;
    dir_t            ld;
    logic [NowW-1:0] now;
    now     = step.now_ms;
    expired = (now - start_q) >= {{(NowW-LenW){1'b0}}, len_q};
    spin    = step.rand_turn_right ? CMD_SPIN_R : CMD_SPIN_L;
    if (step.echo_us != '0 && step.echo_us < near_q) begin
      if (mode_q != MODE_BACK) begin
        enter_phase(MODE_BACK, now, LenReverse, CMD_BACK);
      end else if (expired) begin
        enter_phase(MODE_TURN, now, LenShortTurn, spin);
      end
    end else if (step.echo_us != '0 && step.echo_us < warn_q) begin
      if (mode_q != MODE_TURN && expired) begin
        enter_phase(MODE_TURN, now, step.rand_long_turn ? LenLongTurn : LenShortTurn, spin);
      end else if (mode_q == MODE_TURN && expired) begin
        enter_phase(MODE_FWD, now, LenStraight, CMD_FWD);
      end
    end else if (mode_q != MODE_FWD || expired) begin
      if (step.rand_choice == ChoiceSpinL) begin
        enter_phase(MODE_FWD, now, LenLongTurn, CMD_SPIN_L);
      end else if (step.rand_choice == ChoiceSpinR) begin
        enter_phase(MODE_FWD, now, LenLongTurn, CMD_SPIN_R);
      end else begin
        enter_phase(MODE_FWD, now, LenStraight, CMD_FWD);
      end
    end
    case (cmd_q)
      CMD_FWD: begin
        rd = DIR_FWD;
        ld = DIR_FWD;
      end
      CMD_BACK: begin
        rd = DIR_BACK;
        ld = DIR_BACK;
      end
      CMD_SPIN_L: begin
        rd = DIR_FWD;
        ld = DIR_BACK;
      end
      CMD_SPIN_R: begin
        rd = DIR_BACK;
        ld = DIR_FWD;
      end
      default: begin
        rd = DIR_STOP;
        ld = DIR_STOP;
      end
    endcase
    d.right_dir = rd;
    d.right_pwm = (rd != DIR_STOP) ? speed_q : '0;
    d.left_dir  = ld;
    d.left_pwm  = (ld != DIR_STOP) ? speed_q : '0;
    d.mode      = mode_q;
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      mode_q  = MODE_FWD;
      start_q = '0;
      len_q   = '0;
      cmd_q   = CMD_STOP;
      speed_q = DriveSpeedReset;
      near_q  = NearLimitReset;
      warn_q  = WarnLimitReset;
      expected_drive_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_DRIVE_SPEED: speed_q = pwdata[PwmW-1:0];
          REG_NEAR_LIMIT:  near_q  = pwdata[EchoW-1:0];
          REG_WARN_LIMIT:  warn_q  = pwdata[EchoW-1:0];
          default: ;
        endcase
      end
      if (drive.valid && drive.ready) begin
        if (expected_drive_q.size() == 0) begin
          errors++;
          $display("%0t: drive word with no step pending, expected none, got %0d/%0d %0d/%0d %0d",
                   $time, drive.right_dir, drive.right_pwm, drive.left_dir, drive.left_pwm,
                   drive.mode);
        end else begin
          want = expected_drive_q.pop_front();
          check_field("right_dir", want.right_dir, drive.right_dir);
          check_field("right_pwm", want.right_pwm, drive.right_pwm);
          check_field("left_dir", want.left_dir, drive.left_dir);
          check_field("left_pwm", want.left_pwm, drive.left_pwm);
          check_field("mode", want.mode, drive.mode);
        end
      end
      if (step.valid && step.ready) begin
        predict_drive(want);
        expected_drive_q.push_back(want);
      end
      pending = expected_drive_q.size();
    end
  end

endmodule

FILE: tb/sv/obstacle_avoid_drive_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_sequencer_core_tb
// Drives control steps into the drive sequencer with random gaps and random
// stalls on the drive channel, walks the speed and echo limit registers
// through several settings, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 108;
  localparam int DrainCycles = 8;
  localparam int EchoMax     = 20000;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [oads_pkg::CfgAddrW-1:0] paddr;
  logic [oads_pkg::CfgDataW-1:0] pwdata;
  logic [oads_pkg::CfgDataW-1:0] prdata;
  logic pready;
  int   fail_count;
  int   pending_count;
  int   cycle_cnt = 0;
  int   burst_left = 0;
  logic [31:0] now_t;
  int   cur_near;
  int   cur_warn;

  oads_step_if  step_ch ();
  oads_drive_if drive_ch ();

  obstacle_avoid_drive_sequencer_core dut (
    .clk     (clk),
    .rst     (rst),
    .step    (step_ch),
    .drive   (drive_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  oads_drive_checker drive_checker (
    .clk     (clk),
    .rst     (rst),
    .step    (step_ch),
    .drive   (drive_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (fail_count),
    .pending (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int hold_cnt;
    int calm_cnt;
    int r;
    hold_cnt = 0;
    calm_cnt = 0;
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt != 0) begin
        drive_ch.ready <= 1'b0;
        hold_cnt--;
      end else begin
        drive_ch.ready <= 1'b1;
        if (calm_cnt != 0) begin
          calm_cnt--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 15) hold_cnt = $urandom_range(1, 3);
          else if (r < 18) hold_cnt = $urandom_range(10, 40);
          else if (r < 20) calm_cnt = $urandom_range(30, 100);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(8, 30);
    if (r < 90) burst_left = $urandom_range(20, 60);
    return 0;
  endfunction

  function automatic logic [14:0] pick_echo();
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 35 && cur_near > 1) begin
      hi = (cur_near - 1 > EchoMax) ? EchoMax : cur_near - 1;
      return 15'($urandom_range(1, hi));
    end
    if (r >= 35 && r < 60) begin
      lo = (cur_near < 1) ? 1 : cur_near;
      hi = (cur_warn - 1 > EchoMax) ? EchoMax : cur_warn - 1;
      if (lo <= hi) return 15'($urandom_range(lo, hi));
    end
    if (r >= 60 && r < 80) begin
      lo = (cur_warn < 1) ? 1 : cur_warn;
      if (lo <= EchoMax) return 15'($urandom_range(lo, EchoMax));
    end
    if (r >= 80 && r < 90) begin
      case ($urandom_range(0, 3))
        0: lo = cur_near - 1;
        1: lo = cur_near;
        2: lo = cur_warn - 1;
        default: lo = cur_warn;
      endcase
      if (lo >= 0 && lo <= EchoMax) return 15'(lo);
    end
    return 15'($urandom_range(0, EchoMax));
  endfunction

  task automatic send_step(input logic [31:0] now, input logic [14:0] echo,
                           input logic long_turn, input logic turn_right,
                           input logic [3:0] choice);
    int   gap;
    logic took;
    gap = pick_gap();
    if (gap > 0) begin
      step_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_ch.valid           <= 1'b1;
    step_ch.now_ms          <= now;
    step_ch.echo_us         <= echo;
    step_ch.rand_long_turn  <= long_turn;
    step_ch.rand_turn_right <= turn_right;
    step_ch.rand_choice     <= choice;
    do begin
      @(negedge clk);
      took = step_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_random_step();
    int          r;
    logic [31:0] dt;
    logic [3:0]  choice;
    r = $urandom_range(0, 99);
    if (r < 55) dt = $urandom_range(0, 400);
    else if (r < 85) dt = $urandom_range(700, 2100);
    else if (r < 95) dt = $urandom_range(2100, 5000);
    else dt = $urandom;
    now_t = now_t + dt;
    if ($urandom_range(0, 99) < 70) choice = 4'($urandom_range(1, 10));
    else choice = 4'($urandom_range(0, 15));
    send_step(now_t, pick_echo(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              choice);
  endtask

  task automatic write_reg(input oads_pkg::reg_idx_t idx, input logic [31:0] value);
    logic took;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      took = pready;
      @(posedge clk);
    end while (!took);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == oads_pkg::REG_NEAR_LIMIT) cur_near = int'(value);
    if (idx == oads_pkg::REG_WARN_LIMIT) cur_warn = int'(value);
  endtask

  task automatic settle();
    do @(negedge clk); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    logic [31:0] speed;
    logic [31:0] near;
    logic [31:0] warn;
    rst                     <= 1'b1;
    step_ch.valid           <= 1'b0;
    step_ch.now_ms          <= '0;
    step_ch.echo_us         <= '0;
    step_ch.rand_long_turn  <= 1'b0;
    step_ch.rand_turn_right <= 1'b0;
    step_ch.rand_choice     <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    cur_near = int'(oads_pkg::NearLimitReset);
    cur_warn = int'(oads_pkg::WarnLimitReset);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_step(32'd0, 15'd0, 1'b0, 1'b0, 4'd5);
    send_step(32'd100, 15'd0, 1'b0, 1'b0, 4'd1);
    send_step(32'd2000, 15'd0, 1'b0, 1'b0, 4'd1);
    send_step(32'd3500, 15'd0, 1'b0, 1'b0, 4'd2);
    send_step(32'd5000, 15'd0, 1'b1, 1'b1, 4'd0);
    send_step(32'd7000, 15'd0, 1'b0, 1'b0, 4'd15);
    send_step(32'd7100, 15'd1000, 1'b1, 1'b1, 4'd3);
    send_step(32'd9000, 15'd1000, 1'b1, 1'b1, 4'd3);
    send_step(32'd9500, 15'd1000, 1'b0, 1'b0, 4'd3);
    send_step(32'd10500, 15'd1199, 1'b0, 1'b1, 4'd3);
    send_step(32'd10600, 15'd749, 1'b1, 1'b1, 4'd7);
    send_step(32'd11000, 15'd1, 1'b1, 1'b1, 4'd7);
    send_step(32'd11600, 15'd500, 1'b1, 1'b0, 4'd7);
    send_step(32'd11700, 15'd500, 1'b0, 1'b1, 4'd7);
    send_step(32'd12700, 15'd20000, 1'b0, 1'b0, 4'd2);
    send_step(32'd12800, 15'd750, 1'b1, 1'b0, 4'd1);
    send_step(32'd14800, 15'd1200, 1'b0, 1'b0, 4'd3);
    send_step(32'd16800, 15'd800, 1'b0, 1'b0, 4'd9);
    send_step(32'd17600, 15'd16384, 1'b1, 1'b1, 4'd10);
    send_step(32'hFFFF_FF00, 15'd0, 1'b0, 1'b0, 4'd4);
    send_step(32'h0000_0100, 15'd0, 1'b0, 1'b0, 4'd1);
    send_step(32'h0000_0700, 15'd0, 1'b0, 1'b0, 4'd11);
    send_step(32'hFFFF_FFFF, 15'd20000, 1'b1, 1'b1, 4'd14);
    now_t = 32'hFFFF_FFFF;

    for (int p = 0; p < 6; p++) begin
      step_ch.valid <= 1'b0;
      settle();
      case (p)
        0: begin
          speed = 0;
          near  = 0;
          warn  = 0;
        end
        1: begin
          speed = 255;
          near  = EchoMax;
          warn  = EchoMax;
        end
        2: begin
          speed = 200;
          near  = 1500;
          warn  = 800;
        end
        3: begin
          speed = 1;
          near  = 300;
          warn  = 9000;
        end
        4: begin
          speed = 32'(oads_pkg::DriveSpeedReset);
          near  = 32'(oads_pkg::NearLimitReset);
          warn  = 32'(oads_pkg::WarnLimitReset);
        end
        default: begin
          speed = $urandom_range(0, 255);
          near  = $urandom_range(0, EchoMax);
          warn  = $urandom_range(0, EchoMax);
        end
      endcase
      write_reg(oads_pkg::REG_DRIVE_SPEED, speed);
      write_reg(oads_pkg::REG_NEAR_LIMIT, near);
      write_reg(oads_pkg::REG_WARN_LIMIT, warn);
      repeat (PhaseItems) send_random_step();
    end

    step_ch.valid <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/oads_pkg.sv
rtl/oads_if.sv
rtl/obstacle_avoid_drive_sequencer_core.sv
tb/sv/oads_drive_checker.sv
tb/sv/obstacle_avoid_drive_sequencer_core_tb.sv
